FILE: rtl/dlqm_pkg.sv
// Shared types and codes for the doubly linked queue manager.
// Used by dlqm_alu and doubly_linked_queue_manager; depends on nothing.
`default_nettype none

package dlqm_pkg;

    localparam int DEF_NODE_SLOTS = 64;
    localparam int DEF_SIZE_BITS  = 16;

    localparam logic [1:0] REQ_PUSH   = 2'd0;
    localparam logic [1:0] REQ_POP    = 2'd1;
    localparam logic [1:0] REQ_REMOVE = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [5:0]  node_index;
        logic [15:0] byte_size;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  popped_index;
        logic [6:0]  node_count;
        logic [21:0] byte_total;
    } t_rsp;

    typedef struct packed {
        logic sub;
        logic inc_one;
    } t_alu_op;

endpackage

`default_nettype wire

FILE: rtl/dlqm_alu.sv
// Shared add/subtract unit for the node count and the byte total.
// Depends on dlqm_pkg for the operation struct.
`default_nettype none

module dlqm_alu #(
    parameter int BW = 23
) (
    input  dlqm_pkg::t_alu_op i_op,
    input  logic [BW-1:0]     i_a,
    input  logic [BW-1:0]     i_b,
    output logic [BW-1:0]     o_y
);

    logic [BW-1:0] w_b;

    assign w_b = i_op.inc_one ? BW'(1) : i_b;
    assign o_y = i_op.sub ? (i_a - w_b) : (i_a + w_b);

endmodule

`default_nettype wire

FILE: rtl/doubly_linked_queue_manager.sv
// Top level of the doubly linked queue manager: sequencer, link memories, list registers.
// Depends on dlqm_pkg and dlqm_alu.
//
// Usage:
// Requests enter on i_in_valid / o_in_stall with payload i_in_req; results leave on
// o_out_valid / i_out_stall with payload o_out_rsp, one result per request, in order.
// A request is taken while the sequencer is idle. Its links are read from and written
// to one-read one-write link and size memories, and the count and byte total are updated
// through one shared adder, one value per cycle.
// A push passes through S_PUSH_A, S_PUSH_B and S_DONE; a pop or remove through S_READ,
// S_UNL_A, S_UNL_B and S_DONE; a rejected or empty request goes straight to S_DONE,
// where the result is registered. The sequencer then returns to S_IDLE and takes the
// next request only after the result of the last one is registered.
// The result sits in an output register, so the next request is taken while it
// waits. If the receiver stalls and the register is still full when the next result
// is ready, the sequencer holds that result until the register frees up.
// Reset empties the list and clears all membership bits; link and size memories
// are not cleared and need no clearing pass.
`default_nettype none

module doubly_linked_queue_manager #(
    parameter int NODE_SLOTS = dlqm_pkg::DEF_NODE_SLOTS,
    parameter int SIZE_BITS  = dlqm_pkg::DEF_SIZE_BITS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  dlqm_pkg::t_req i_in_req,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output dlqm_pkg::t_rsp o_out_rsp
);

    localparam int AW = (NODE_SLOTS > 1) ? $clog2(NODE_SLOTS) : 1;
    localparam int LW = $clog2(NODE_SLOTS + 1);
    localparam int BW = SIZE_BITS + LW;
    localparam int CW = (LW > 6) ? LW : 6;
    localparam logic [LW-1:0] NIL = LW'(NODE_SLOTS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_PUSH_A,
        S_PUSH_B,
        S_UNL_A,
        S_UNL_B,
        S_DONE
    } t_state;

    t_state                r_state;
    logic [AW-1:0]         r_slot;
    logic [SIZE_BITS-1:0]  r_size;
    logic [1:0]            r_status;
    logic [AW-1:0]         r_popped;
    logic [AW-1:0]         r_head;
    logic [AW-1:0]         r_tail;
    logic [LW-1:0]         r_count;
    logic [BW-1:0]         r_bytes;
    logic [NODE_SLOTS-1:0] r_in_list;

    logic [LW-1:0]         m_next [NODE_SLOTS];
    logic [LW-1:0]         m_prev [NODE_SLOTS];
    logic [SIZE_BITS-1:0]  m_size [NODE_SLOTS];
    logic [LW-1:0]         r_next_q;
    logic [LW-1:0]         r_prev_q;
    logic [SIZE_BITS-1:0]  r_size_q;

    logic                  w_in_take;
    logic                  w_out_free;
    logic                  w_idx_ok;
    logic [AW-1:0]         w_idx_slot;

    logic                  w_nx_we;
    logic [AW-1:0]         w_nx_addr;
    logic [LW-1:0]         w_nx_data;
    logic                  w_pv_we;
    logic [AW-1:0]         w_pv_addr;
    logic [LW-1:0]         w_pv_data;
    logic                  w_sz_we;

    dlqm_pkg::t_alu_op     w_alu_op;
    logic [BW-1:0]         w_alu_a;
    logic [BW-1:0]         w_alu_b;
    logic [BW-1:0]         w_alu_y;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_take  = i_in_valid && (r_state == S_IDLE);
    assign w_out_free = !o_out_valid || !i_out_stall;
    assign w_idx_ok   = CW'(i_in_req.node_index) < CW'(NODE_SLOTS);
    assign w_idx_slot = AW'(i_in_req.node_index);

    dlqm_alu #(
        .BW (BW)
    ) u_alu (
        .i_op (w_alu_op),
        .i_a  (w_alu_a),
        .i_b  (w_alu_b),
        .o_y  (w_alu_y)
    );

    always_comb begin
        w_alu_op.sub     = (r_state == S_UNL_A) || (r_state == S_UNL_B);
        w_alu_op.inc_one = (r_state == S_PUSH_B) || (r_state == S_UNL_B);
        w_alu_a          = r_bytes;
        w_alu_b          = BW'(r_size);
        unique case (r_state)
            S_PUSH_B, S_UNL_B: w_alu_a = BW'(r_count);
            S_UNL_A:           w_alu_b = BW'(r_size_q);
            default:           w_alu_a = r_bytes;
        endcase
    end

    always_comb begin
        w_nx_we   = 1'b0;
        w_nx_addr = r_slot;
        w_nx_data = NIL;
        w_pv_we   = 1'b0;
        w_pv_addr = r_slot;
        w_pv_data = NIL;
        w_sz_we   = 1'b0;
        unique case (r_state)
            S_PUSH_A: begin
                w_nx_we   = 1'b1;
                w_pv_we   = 1'b1;
                w_pv_data = (r_count != '0) ? LW'(r_tail) : NIL;
                w_sz_we   = 1'b1;
            end
            S_PUSH_B: begin
                w_nx_we   = (r_count != '0);
                w_nx_addr = r_tail;
                w_nx_data = LW'(r_slot);
            end
            S_UNL_A: begin
                w_nx_we   = (r_prev_q != NIL);
                w_nx_addr = AW'(r_prev_q);
                w_nx_data = r_next_q;
                w_pv_we   = (r_next_q != NIL);
                w_pv_addr = AW'(r_next_q);
                w_pv_data = r_prev_q;
            end
            default: begin
                w_nx_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_nx_we) begin
            m_next[w_nx_addr] <= w_nx_data;
        end
        if (w_pv_we) begin
            m_prev[w_pv_addr] <= w_pv_data;
        end
        if (w_sz_we) begin
            m_size[r_slot] <= r_size;
        end
        r_next_q <= m_next[r_slot];
        r_prev_q <= m_prev[r_slot];
        r_size_q <= m_size[r_slot];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_bytes     <= '0;
            r_in_list   <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall && (r_state != S_DONE)) begin
                o_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_take) begin
                        r_size <= SIZE_BITS'(i_in_req.byte_size);
                        if ((i_in_req.req_type == dlqm_pkg::REQ_POP) && (r_count != '0)) begin
                            r_slot   <= r_head;
                            r_popped <= r_head;
                        end else begin
                            r_slot   <= w_idx_slot;
                            r_popped <= '0;
                        end
                        unique case (i_in_req.req_type)
                            dlqm_pkg::REQ_PUSH: begin
                                if (!w_idx_ok || r_in_list[w_idx_slot]) begin
                                    r_status <= dlqm_pkg::ST_INVALID;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_status <= dlqm_pkg::ST_OK;
                                    r_state  <= S_PUSH_A;
                                end
                            end
                            dlqm_pkg::REQ_POP: begin
                                if (r_count == '0) begin
                                    r_status <= dlqm_pkg::ST_EMPTY;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_status <= dlqm_pkg::ST_OK;
                                    r_state  <= S_READ;
                                end
                            end
                            dlqm_pkg::REQ_REMOVE: begin
                                if (!w_idx_ok || !r_in_list[w_idx_slot]) begin
                                    r_status <= dlqm_pkg::ST_INVALID;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_status <= dlqm_pkg::ST_OK;
                                    r_state  <= S_READ;
                                end
                            end
                            default: begin
                                r_status <= dlqm_pkg::ST_INVALID;
                                r_state  <= S_DONE;
                            end
                        endcase
                    end
                end
                S_READ: begin
                    r_state <= S_UNL_A;
                end
                S_PUSH_A: begin
                    r_bytes <= w_alu_y;
                    r_state <= S_PUSH_B;
                end
                S_PUSH_B: begin
                    r_count <= LW'(w_alu_y);
                    if (r_count == '0) begin
                        r_head <= r_slot;
                    end
                    r_tail            <= r_slot;
                    r_in_list[r_slot] <= 1'b1;
                    r_state           <= S_DONE;
                end
                S_UNL_A: begin
                    r_bytes <= w_alu_y;
                    if (r_prev_q == NIL) begin
                        r_head <= (r_next_q != NIL) ? AW'(r_next_q) : '0;
                    end
                    if (r_next_q == NIL) begin
                        r_tail <= (r_prev_q != NIL) ? AW'(r_prev_q) : '0;
                    end
                    r_state <= S_UNL_B;
                end
                S_UNL_B: begin
                    r_count           <= LW'(w_alu_y);
                    r_in_list[r_slot] <= 1'b0;
                    r_state           <= S_DONE;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        o_out_valid             <= 1'b1;
                        o_out_rsp.status        <= r_status;
                        o_out_rsp.popped_index  <= 6'(r_popped);
                        o_out_rsp.node_count    <= 7'(r_count);
                        o_out_rsp.byte_total    <= 22'(r_bytes);
                        r_state                 <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_count_matches_members: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_in_list) == int'(r_count))
        else $error("node count differs from membership bits");

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_count) <= NODE_SLOTS)
        else $error("node count above slot count");

    a_empty_has_zero_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_rsp.status == dlqm_pkg::ST_EMPTY)
            |-> (o_out_rsp.node_count == 7'd0 && o_out_rsp.byte_total == 22'd0))
        else $error("empty status with nonempty list");

    a_popped_only_on_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_rsp.status != dlqm_pkg::ST_OK)
            |-> (o_out_rsp.popped_index == 6'd0))
        else $error("popped index set on failed request");

endmodule

`default_nettype wire

FILE: sim/tb_doubly_linked_queue_manager.sv
// Testbench for doubly_linked_queue_manager: push, pop and remove requests checked against
// an in-bench list predictor, with random gaps on the request side and random output stalls.
// Depends on dlqm_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_doubly_linked_queue_manager;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int         SLOTS      = dlqm_pkg::DEF_NODE_SLOTS;
    localparam logic [6:0] NO_LINK    = 7'd64;
    localparam int         MAX_SHOWN  = 10;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    logic in_stall;
    dlqm_pkg::t_req in_req = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    dlqm_pkg::t_rsp out_rsp;

    logic [5:0]  list_head;
    logic [5:0]  list_tail;
    logic [6:0]  link_next [SLOTS];
    logic [6:0]  link_prev [SLOTS];
    logic [15:0] node_bytes [SLOTS];
    logic        listed [SLOTS];
    logic [6:0]  list_count;
    logic [22:0] list_bytes;

    dlqm_pkg::t_rsp due_responses[$];
    int   mismatches  = 0;
    bit   no_idle     = 1'b0;
    bit   grow        = 1'b1;
    int   fill_target = 16;
    int   stall_left  = 0;

    always #1 clk = ~clk;

    doubly_linked_queue_manager #(
        .NODE_SLOTS(SLOTS),
        .SIZE_BITS (dlqm_pkg::DEF_SIZE_BITS)
    ) u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_req   (in_req),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_rsp  (out_rsp)
    );

    function automatic void clear_list();
        list_head  = '0;
        list_tail  = '0;
        list_count = '0;
        list_bytes = '0;
        for (int k = 0; k < SLOTS; k++) begin
            link_next[k]  = NO_LINK;
            link_prev[k]  = NO_LINK;
            node_bytes[k] = '0;
            listed[k]     = 1'b0;
        end
    endfunction

    function automatic void detach_slot(input logic [5:0] s);
        logic [6:0] p;
        logic [6:0] n;
        p = link_prev[s];
        n = link_next[s];
        if (!p[6]) begin
            link_next[p[5:0]] = n;
        end else begin
            list_head = n[6] ? 6'd0 : n[5:0];
        end
        if (!n[6]) begin
            link_prev[n[5:0]] = p;
        end else begin
            list_tail = p[6] ? 6'd0 : p[5:0];
        end
        link_next[s] = NO_LINK;
        link_prev[s] = NO_LINK;
        listed[s]    = 1'b0;
        list_count   = list_count - 7'd1;
        list_bytes   = list_bytes - 23'(node_bytes[s]);
        if (list_count == 7'd0) begin
            list_head = '0;
            list_tail = '0;
        end
    endfunction

    function automatic dlqm_pkg::t_rsp list_update(input dlqm_pkg::t_req r);
        dlqm_pkg::t_rsp rsp;
        logic [5:0]     s;
        rsp        = '0;
        rsp.status = dlqm_pkg::ST_OK;
        s          = r.node_index;
        case (r.req_type)
            dlqm_pkg::REQ_PUSH: begin
                if (listed[s]) begin
                    rsp.status = dlqm_pkg::ST_INVALID;
                end else begin
                    link_next[s]  = NO_LINK;
                    node_bytes[s] = r.byte_size;
                    if (list_count != 7'd0) begin
                        link_prev[s]         = {1'b0, list_tail};
                        link_next[list_tail] = {1'b0, s};
                    end else begin
                        link_prev[s] = NO_LINK;
                        list_head    = s;
                    end
                    list_tail  = s;
                    listed[s]  = 1'b1;
                    list_count = list_count + 7'd1;
                    list_bytes = list_bytes + 23'(r.byte_size);
                end
            end
            dlqm_pkg::REQ_POP: begin
                if (list_count == 7'd0) begin
                    rsp.status = dlqm_pkg::ST_EMPTY;
                end else begin
                    rsp.popped_index = list_head;
                    detach_slot(list_head);
                end
            end
            dlqm_pkg::REQ_REMOVE: begin
                if (!listed[s]) begin
                    rsp.status = dlqm_pkg::ST_INVALID;
                end else begin
                    detach_slot(s);
                end
            end
            default: rsp.status = dlqm_pkg::ST_INVALID;
        endcase
        rsp.node_count = list_count;
        rsp.byte_total = list_bytes[21:0];
        return rsp;
    endfunction

    function automatic int random_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (no_idle || roll < 45) begin
            return 0;
        end else if (roll < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 24);
    endfunction

    function automatic logic [15:0] rand_size();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [5:0] rand_slot();
        return 6'($urandom_range(0, SLOTS - 1));
    endfunction

    function automatic logic [5:0] pick_listed();
        logic [5:0] s;
        int         steps;
        if (list_count == 7'd0) begin
            return rand_slot();
        end
        steps = $urandom_range(0, int'(list_count) - 1);
        s     = list_head;
        repeat (steps) s = link_next[s][5:0];
        return s;
    endfunction

    function automatic logic [5:0] pick_unlisted();
        logic [5:0] s;
        if (int'(list_count) == SLOTS) begin
            return rand_slot();
        end
        do s = rand_slot(); while (listed[s]);
        return s;
    endfunction

    task automatic send_request(input logic [1:0] kind, input logic [5:0] slot,
                                input logic [15:0] size);
        dlqm_pkg::t_req r;
        int             gap;
        r.req_type   = kind;
        r.node_index = slot;
        r.byte_size  = size;
        gap          = random_gap();
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_req   <= r;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        due_responses.push_back(list_update(r));
    endtask

    task automatic test_empty_and_invalid();
        send_request(dlqm_pkg::REQ_POP, 6'd0, 16'h0000);
        send_request(dlqm_pkg::REQ_REMOVE, 6'd5, 16'h0000);
        send_request(REQ_UNUSED, 6'd63, 16'hffff);
        send_request(dlqm_pkg::REQ_PUSH, 6'd0, 16'h0000);
        send_request(dlqm_pkg::REQ_PUSH, 6'd0, 16'h1234);
        send_request(REQ_UNUSED, 6'd0, 16'h0000);
        send_request(dlqm_pkg::REQ_POP, 6'd17, 16'hffff);
        send_request(dlqm_pkg::REQ_POP, 6'd0, 16'h0000);
    endtask

    task automatic test_link_updates();
        send_request(dlqm_pkg::REQ_PUSH, 6'd63, 16'hffff);
        send_request(dlqm_pkg::REQ_PUSH, 6'd21, 16'h5555);
        send_request(dlqm_pkg::REQ_PUSH, 6'd42, 16'haaaa);
        send_request(dlqm_pkg::REQ_PUSH, 6'd0, 16'h0001);
        send_request(dlqm_pkg::REQ_REMOVE, 6'd21, 16'h0000);
        send_request(dlqm_pkg::REQ_REMOVE, 6'd0, 16'hffff);
        send_request(dlqm_pkg::REQ_REMOVE, 6'd63, 16'h0000);
        send_request(dlqm_pkg::REQ_POP, 6'd63, 16'h0000);
        send_request(dlqm_pkg::REQ_PUSH, 6'd42, 16'h0000);
        send_request(dlqm_pkg::REQ_REMOVE, 6'd42, 16'h0000);
        send_request(dlqm_pkg::REQ_REMOVE, 6'd42, 16'h0000);
        send_request(dlqm_pkg::REQ_PUSH, 6'd7, 16'h8000);
        send_request(dlqm_pkg::REQ_PUSH, 6'd56, 16'h7fff);
        send_request(dlqm_pkg::REQ_POP, 6'd0, 16'h0000);
        send_request(dlqm_pkg::REQ_POP, 6'd0, 16'h0000);
    endtask

    task automatic test_full_pool();
        int order [SLOTS];
        int j;
        int tmp;
        for (int k = 0; k < SLOTS; k++) order[k] = k;
        for (int k = SLOTS - 1; k > 0; k--) begin
            j        = $urandom_range(0, k);
            tmp      = order[k];
            order[k] = order[j];
            order[j] = tmp;
        end
        for (int k = 0; k < SLOTS; k++) begin
            send_request(dlqm_pkg::REQ_PUSH, 6'(order[k]), 16'hffff);
        end
        send_request(dlqm_pkg::REQ_PUSH, 6'(order[SLOTS - 1]), 16'h0000);
        send_request(dlqm_pkg::REQ_POP, rand_slot(), rand_size());
        send_request(dlqm_pkg::REQ_PUSH, 6'(order[0]), 16'hffff);
        while (int'(list_count) > 32) begin
            send_request(dlqm_pkg::REQ_REMOVE, pick_listed(), rand_size());
        end
        while (int'(list_count) > 0) begin
            send_request(dlqm_pkg::REQ_POP, rand_slot(), rand_size());
        end
        send_request(dlqm_pkg::REQ_POP, rand_slot(), rand_size());
    endtask

    task automatic test_random_traffic(input int n_items);
        int roll;
        for (int k = 0; k < n_items; k++) begin
            if (grow && int'(list_count) >= fill_target) begin
                grow = 1'b0;
            end else if (!grow && int'(list_count) <= 1) begin
                grow        = 1'b1;
                fill_target = $urandom_range(4, SLOTS);
            end
            roll = $urandom_range(0, 99);
            if (roll < 12) begin
                case ($urandom_range(0, 3))
                    0: send_request(dlqm_pkg::REQ_PUSH, pick_listed(), rand_size());
                    1: send_request(dlqm_pkg::REQ_REMOVE, pick_unlisted(), rand_size());
                    2: send_request(REQ_UNUSED, rand_slot(), rand_size());
                    default: send_request(dlqm_pkg::REQ_POP, rand_slot(), rand_size());
                endcase
            end else if (roll < (grow ? 72 : 32)) begin
                send_request(dlqm_pkg::REQ_PUSH, pick_unlisted(), rand_size());
            end else if (roll < (grow ? 84 : 66)) begin
                send_request(dlqm_pkg::REQ_POP, rand_slot(), rand_size());
            end else begin
                send_request(dlqm_pkg::REQ_REMOVE, pick_listed(), rand_size());
            end
        end
    endtask

    task automatic test_back_to_back();
        no_idle = 1'b1;
        test_random_traffic(60);
        no_idle = 1'b0;
    endtask

    always @(posedge clk) begin
        if (!rst_n || no_idle) begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else begin
            out_stall  <= ($urandom_range(0, 2) == 0);
            stall_left <= random_gap();
        end
    end

    always @(posedge clk) begin : check_rsp
        dlqm_pkg::t_rsp want;
        if (rst_n && out_valid && !out_stall) begin
            if (due_responses.size() == 0) begin
                if (mismatches < MAX_SHOWN) begin
                    $display("unexpected response: status %0d popped %0d count %0d bytes %0d",
                             out_rsp.status, out_rsp.popped_index, out_rsp.node_count,
                             out_rsp.byte_total);
                end
                mismatches++;
            end else begin
                want = due_responses.pop_front();
                if (out_rsp.status !== want.status ||
                    out_rsp.popped_index !== want.popped_index ||
                    out_rsp.node_count !== want.node_count ||
                    out_rsp.byte_total !== want.byte_total) begin
                    if (mismatches < MAX_SHOWN) begin
                        $display("mismatch exp/act: st %0d/%0d pop %0d/%0d cnt %0d/%0d by %0d/%0d",
                                 want.status, out_rsp.status,
                                 want.popped_index, out_rsp.popped_index,
                                 want.node_count, out_rsp.node_count,
                                 want.byte_total, out_rsp.byte_total);
                    end
                    mismatches++;
                end
            end
        end
    end

    initial begin
        clear_list();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        test_empty_and_invalid();
        test_link_updates();
        test_full_pool();
        test_random_traffic(290);
        test_back_to_back();
        in_valid <= 1'b0;
        while (due_responses.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #1000000;
        $display("FAIL");
        $finish;
    end

endmodule
